// ----- rtl/wmed_pkg.sv -----
// ----------------------------------------------------------------------------
// wmed_pkg
// Shared constants, opcodes and controller/datapath interface types for the
// windowed median block.
// ----------------------------------------------------------------------------
`default_nettype none

package wmed_pkg;

  // Default sizing
  localparam int DEPTH_DEF      = 32;
  localparam int VALUE_BITS_DEF = 24;

  // Configuration register
  localparam int CFG_W     = 6;
  localparam int WL_RESET  = 32;
  localparam int WL_MIN    = 2;

  // Input opcodes
  localparam int OPC_W = 1;
  localparam logic [OPC_W-1:0] OP_PUSH  = 1'b0;
  localparam logic [OPC_W-1:0] OP_EMPTY = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;   // capture transaction, read oldest slot
    logic del;      // evict oldest slot, write new slot, advance pointer
    logic ins;      // insert new value into sorted list
    logic scan;     // rotate sorted list one lane, pick middle values
    logic load;     // load output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/wmed_datapath.sv -----
// ----------------------------------------------------------------------------
// wmed_datapath
// History slots, sorted list of valid values with per-lane insert/delete,
// rotating scan that picks the middle values, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wmed_datapath #(
  parameter int DEPTH      = wmed_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = wmed_pkg::VALUE_BITS_DEF
) (
  input  wire                                logic clk,
  input  wire                                logic rst_n,
  input  wire                                logic cfg_wr_en,
  input  wire  logic [wmed_pkg::CFG_W-1:0]         cfg_wr_data,
  input  wire  logic [wmed_pkg::OPC_W-1:0]         in_opcode,
  input  wire  logic [VALUE_BITS-1:0]              in_value_in,
  input  wire  wmed_pkg::dp_cmd_t                  cmd,
  output       wmed_pkg::dp_sts_t                  sts,
  output       logic [VALUE_BITS-1:0]              out_median_out,
  output       logic [$clog2(DEPTH+1)-1:0]         out_valid_count,
  output       logic                               out_has_median
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > wmed_pkg::CFG_W) ? CNT_W : wmed_pkg::CFG_W;
  localparam int WL_RST_I = (wmed_pkg::WL_RESET > DEPTH) ? DEPTH : wmed_pkg::WL_RESET;
  localparam logic [CNT_W-1:0] WL_RST = CNT_W'(WL_RST_I);

  // Control state
  logic [CNT_W-1:0]      wl_r;
  logic [IDX_W-1:0]      ptr_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DEPTH-1:0]      slot_vld_r;
  logic [IDX_W-1:0]      scan_r;

  // Payload registers
  logic [wmed_pkg::OPC_W-1:0] opc_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [VALUE_BITS-1:0] old_val_r;
  logic [VALUE_BITS-1:0] lo_r;
  logic [VALUE_BITS-1:0] hi_r;
  logic [VALUE_BITS-1:0] sorted_r [DEPTH];
  logic [VALUE_BITS-1:0] slot_mem [DEPTH];

  logic [VALUE_BITS-1:0] med_r;
  logic [CNT_W-1:0]      cnt_out_r;
  logic                  has_r;

  // Config clamp to [WL_MIN, DEPTH]
  logic [CMP_W-1:0] cfg_ext;
  logic [CNT_W-1:0] wl_cfg;
  always_comb begin
    cfg_ext = CMP_W'(cfg_wr_data);
    if (cfg_ext < CMP_W'(wmed_pkg::WL_MIN)) begin
      wl_cfg = CNT_W'(wmed_pkg::WL_MIN);
    end else if (cfg_ext > CMP_W'(DEPTH)) begin
      wl_cfg = CNT_W'(DEPTH);
    end else begin
      wl_cfg = cfg_ext[CNT_W-1:0];
    end
  end

  // Pointer advance with wrap at window length
  logic [CNT_W-1:0] ptr_inc;
  logic [IDX_W-1:0] ptr_nxt;
  always_comb begin
    ptr_inc = CNT_W'(ptr_r) + CNT_W'(1);
    ptr_nxt = (ptr_inc >= wl_r) ? '0 : ptr_inc[IDX_W-1:0];
  end

  logic old_vld;
  logic is_push;
  assign old_vld = slot_vld_r[ptr_r];
  assign is_push = (opc_r == wmed_pkg::OP_PUSH);

  // Per-lane delete / insert / rotate candidates
  logic [DEPTH-1:0]      ge_old;
  logic [DEPTH-1:0]      gt_new;
  logic [VALUE_BITS-1:0] del_lane [DEPTH];
  logic [VALUE_BITS-1:0] ins_lane [DEPTH];
  logic [VALUE_BITS-1:0] rot_lane [DEPTH];

  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      ge_old[j] = (CNT_W'(j) >= cnt_r) || (sorted_r[j] >= old_val_r);
      gt_new[j] = (CNT_W'(j) >= cnt_r) || (sorted_r[j] > val_r);
    end
  end

  for (genvar j = 0; j < DEPTH; j++) begin : g_lane
    // delete: lanes at or above the evicted value pull from above
    if (j < DEPTH - 1) begin : g_del
      assign del_lane[j] = ge_old[j] ? sorted_r[j+1] : sorted_r[j];
    end else begin : g_del_top
      assign del_lane[j] = sorted_r[j];
    end
    // insert: first lane above the new value takes it, later lanes shift up
    if (j == 0) begin : g_ins0
      assign ins_lane[j] = gt_new[j] ? val_r : sorted_r[j];
    end else begin : g_ins
      assign ins_lane[j] = !gt_new[j]  ? sorted_r[j] :
                           !gt_new[j-1] ? val_r : sorted_r[j-1];
    end
    // rotate toward lane 0
    assign rot_lane[j] = sorted_r[(j + 1) % DEPTH];
  end

  // Middle ranks
  logic [IDX_W-1:0] k_hi;
  logic [IDX_W-1:0] k_lo;
  always_comb begin
    k_hi = IDX_W'(cnt_r >> 1);
    k_lo = cnt_r[0] ? k_hi : (k_hi - IDX_W'(1));
  end

  // Median from the two picked values
  logic [VALUE_BITS:0] mid_sum;
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};

  // Slot memory: read oldest at accept, write new slot at evict
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      old_val_r <= slot_mem[ptr_r];
    end
    if (cmd.del && is_push) begin
      slot_mem[ptr_r] <= val_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r       <= WL_RST;
      ptr_r      <= '0;
      cnt_r      <= '0;
      slot_vld_r <= '0;
      scan_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        wl_r       <= wl_cfg;
        ptr_r      <= '0;
        cnt_r      <= '0;
        slot_vld_r <= '0;
      end else if (cmd.del) begin
        slot_vld_r[ptr_r] <= is_push;
        ptr_r             <= ptr_nxt;
        if (old_vld) begin
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end else if (cmd.ins && is_push) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      // scan counter
      if (cmd.ins) begin
        scan_r <= '0;
      end else if (cmd.scan) begin
        scan_r <= scan_r + IDX_W'(1);
      end
    end
  end

  // Transaction capture, sorted list and middle pick
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      opc_r <= in_opcode;
      val_r <= in_value_in;
    end
    if (cmd.del && old_vld) begin
      sorted_r <= del_lane;
    end else if (cmd.ins && is_push) begin
      sorted_r <= ins_lane;
    end else if (cmd.scan) begin
      sorted_r <= rot_lane;
    end
    if (cmd.scan && (scan_r == k_lo)) begin
      lo_r <= sorted_r[0];
    end
    if (cmd.scan && (scan_r == k_hi)) begin
      hi_r <= sorted_r[0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      med_r     <= (cnt_r == '0) ? '0 : mid_sum[VALUE_BITS:1];
      cnt_out_r <= cnt_r;
      has_r     <= (cnt_r != '0);
    end
  end

  assign sts.scan_done  = (scan_r == IDX_W'(DEPTH - 1));
  assign out_median_out  = med_r;
  assign out_valid_count = cnt_out_r;
  assign out_has_median  = has_r;

endmodule

`default_nettype wire

// ----- rtl/wmed_ctrl.sv -----
// ----------------------------------------------------------------------------
// wmed_ctrl
// Sequencer for one transaction: evict, insert, rotating scan, output load.
// Owns the input stall and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module wmed_ctrl (
  input  wire  logic              clk,
  input  wire  logic              rst_n,
  input  wire  logic              in_valid,
  output       logic              in_stall,
  output       logic              out_valid,
  input  wire  logic              out_stall,
  input  wire  wmed_pkg::dp_sts_t sts,
  output       wmed_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEL,
    S_INS,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_free;

  // output register can take a new result
  assign out_free = !out_valid_r || !out_stall;

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DEL;
        end
      end
      S_DEL: begin
        cmd.del   = 1'b1;
        state_nxt = S_INS;
      end
      S_INS: begin
        cmd.ins   = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- rtl/windowed_median_with_empty_slots_top.sv -----
// The input stalls from acceptance until the result is loaded, so one transaction
//   is in flight at a time, its pace set by the rotating scan of the sorted list,
//   one lane per cycle.
// A finished result waits in the output register while the next one is taken.
// Reset (synchronous, rst_n low): window length 32 clamped to DEPTH, all slots
//   empty, pointer and valid count zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
// windowed_median_with_empty_slots_top
// Sliding-window median over history slots that may be empty; controller and
// datapath joined by command/status structs.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_median_with_empty_slots_top #(
  parameter int DEPTH      = wmed_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = wmed_pkg::VALUE_BITS_DEF
) (
  input  wire  logic                           clk,
  input  wire  logic                           rst_n,
  // configuration
  input  wire  logic                           cfg_wr_en,
  input  wire  logic [wmed_pkg::CFG_W-1:0]     cfg_wr_data,
  // input channel
  input  wire  logic                           in_valid,
  output       logic                           in_stall,
  input  wire  logic [wmed_pkg::OPC_W-1:0]     in_opcode,
  input  wire  logic [VALUE_BITS-1:0]          in_value_in,
  // result channel
  output       logic                           out_valid,
  input  wire  logic                           out_stall,
  output       logic [VALUE_BITS-1:0]          out_median_out,
  output       logic [$clog2(DEPTH+1)-1:0]     out_valid_count,
  output       logic                           out_has_median
);

  wmed_pkg::dp_cmd_t cmd;
  wmed_pkg::dp_sts_t sts;

  // Sequencer
  wmed_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage and arithmetic
  wmed_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_opcode       (in_opcode),
    .in_value_in     (in_value_in),
    .cmd             (cmd),
    .sts             (sts),
    .out_median_out  (out_median_out),
    .out_valid_count (out_valid_count),
    .out_has_median  (out_has_median)
  );

endmodule

`default_nettype wire

// ----- bench/wmed_checker.sv -----
// ----------------------------------------------------------------------------
// wmed_checker
// Watches the configuration port and both channels of the windowed median
// block. It keeps its own copy of the history window, works out the result of
// every accepted input transaction and compares each result transaction with
// the oldest outstanding one, field by field.
// ----------------------------------------------------------------------------
module wmed_checker #(
  parameter int DEPTH      = wmed_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = wmed_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [wmed_pkg::CFG_W-1:0]      cfg_wr_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [wmed_pkg::OPC_W-1:0]      in_opcode,
  input  logic [VALUE_BITS-1:0]           in_value_in,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [VALUE_BITS-1:0]           out_median_out,
  input  logic [$clog2(DEPTH+1)-1:0]      out_valid_count,
  input  logic                            out_has_median,
  output int                              n_fail,
  output int                              n_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = $clog2(DEPTH+1);

  typedef struct packed {
    logic [VALUE_BITS-1:0] median;
    logic [CW-1:0]         count;
    logic                  has;
  } median_result_t;

  // Model of the history window
  logic [VALUE_BITS-1:0] hist_value [DEPTH];
  bit                    hist_full  [DEPTH];
  int unsigned           write_ptr;
  int unsigned           live_count;
  int unsigned           win_len;

  // Results still owed by the block, oldest first
  median_result_t results_due [$];

  function automatic int unsigned clamp_window(input int unsigned len);
    if (len < wmed_pkg::WL_MIN) return wmed_pkg::WL_MIN;
    if (len > DEPTH) return DEPTH;
    return len;
  endfunction

  function automatic void clear_history();
    for (int i = 0; i < DEPTH; i++) begin
      hist_value[i] = '0;
      hist_full[i]  = 1'b0;
    end
    write_ptr  = 0;
    live_count = 0;
  endfunction

  // Push one slot over the oldest one, then take the median of what is live
  function automatic median_result_t push_slot(input logic [wmed_pkg::OPC_W-1:0] op,
                                               input logic [VALUE_BITS-1:0] val);
    logic [VALUE_BITS-1:0] sorted [DEPTH];
    logic [VALUE_BITS:0]   pair_sum;
    median_result_t        res;
    int unsigned           p;
    int unsigned           n;
    int unsigned           j;
    p = write_ptr;
    if (p >= win_len) p = 0;
    if (hist_full[p]) live_count--;
    if (op == wmed_pkg::OP_PUSH) begin
      hist_value[p] = val;
      hist_full[p]  = 1'b1;
      live_count++;
    end else begin
      hist_value[p] = '0;
      hist_full[p]  = 1'b0;
    end
    p++;
    if (p >= win_len) p = 0;
    write_ptr = p;

    // insertion sort of the live slots
    n = 0;
    for (int i = 0; i < win_len; i++) begin
      if (hist_full[i]) begin
        j = n;
        while (j > 0 && sorted[j-1] > hist_value[i]) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = hist_value[i];
        n++;
      end
    end

    res.count = CW'(live_count);
    res.has   = (live_count != 0);
    if (n == 0) begin
      res.median = '0;
    end else if (n[0]) begin
      res.median = sorted[n >> 1];
    end else begin
      // mean of the two middle values, sum kept one bit wider
      pair_sum   = {1'b0, sorted[(n >> 1) - 1]} + {1'b0, sorted[n >> 1]};
      res.median = pair_sum[VALUE_BITS:1];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t ns: MISMATCH %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    n_fail++;
  endtask

  // Track configuration and input transactions, check result transactions
  always @(posedge clk) begin : track
    median_result_t want;
    if (!rst_n) begin
      win_len = clamp_window(wmed_pkg::WL_RESET);
      clear_history();
      results_due.delete();
      n_fail = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with nothing outstanding, median", 0, out_median_out);
        end else begin
          want = results_due.pop_front();
          if (out_median_out !== want.median)
            report_mismatch("median_out", want.median, out_median_out);
          if (out_valid_count !== want.count)
            report_mismatch("valid_count", want.count, out_valid_count);
          if (out_has_median !== want.has)
            report_mismatch("has_median", want.has, out_has_median);
        end
      end
      if (cfg_wr_en) begin
        win_len = clamp_window(cfg_wr_data);
        clear_history();
      end
      if (in_valid && !in_stall)
        results_due.push_back(push_slot(in_opcode, in_value_in));
    end
    n_pending <= results_due.size();
  end

endmodule

// ----- bench/windowed_median_with_empty_slots_top_test.sv -----
// ----------------------------------------------------------------------------
// windowed_median_with_empty_slots_top_test
// Drives the windowed median block through directed corner cases and random
// pushes over a range of window lengths, with the sender idling and the
// receiver stalling in turn, plus one long receiver hold-off that backs the
// block up. Checking is done by wmed_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module windowed_median_with_empty_slots_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH          = wmed_pkg::DEPTH_DEF;
  localparam int VB             = wmed_pkg::VALUE_BITS_DEF;
  localparam int CFG_W          = wmed_pkg::CFG_W;
  localparam int OPC_W          = wmed_pkg::OPC_W;
  localparam int CW             = $clog2(DEPTH+1);
  localparam int N_PHASES       = 8;
  localparam int PHASE_ITEMS    = 100;
  localparam int PRESSURE_PHASE = 4;
  localparam int HOLD_CYCLES    = 600;
  // settle time after the block drains
  localparam int SETTLE         = DEPTH + 8;
  // worst quiet stretch is the hold-off plus one item; taken several times over
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [CFG_W-1:0]  cfg_wr_data;
  logic              in_valid;
  logic              in_stall;
  logic [OPC_W-1:0]  in_opcode;
  logic [VB-1:0]     in_value_in;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [VB-1:0]     out_median_out;
  logic [CW-1:0]     out_valid_count;
  logic              out_has_median;

  int                n_fail;
  int                n_pending;
  idle_mode_t        idle_mode   = IDLE_NONE;
  int                phase_no    = -1;
  int unsigned       hold_left   = 0;
  bit                hold_done   = 1'b0;
  int unsigned       idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  windowed_median_with_empty_slots_top #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VB)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_value_in     (in_value_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_median_out  (out_median_out),
    .out_valid_count (out_valid_count),
    .out_has_median  (out_has_median)
  );

  wmed_checker #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VB)
  ) chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_value_in     (in_value_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_median_out  (out_median_out),
    .out_valid_count (out_valid_count),
    .out_has_median  (out_has_median),
    .n_fail          (n_fail),
    .n_pending       (n_pending)
  );

  // Offer one input transaction, with random idle cycles ahead of it
  task automatic send_item(input logic [OPC_W-1:0] op, input logic [VB-1:0] val);
    int unsigned gap_pct;
    gap_pct = (idle_mode == IDLE_SENDER) ? 69 : (idle_mode == IDLE_BOTH) ? 30 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_value_in <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Let the block go idle, then set a new window length
  task automatic write_window(input logic [CFG_W-1:0] len);
    in_valid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Receiver: random stalls, and one long hold-off in the pressure phase
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (phase_no == PRESSURE_PHASE && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) <
                    ((idle_mode == IDLE_RECEIVER) ? 69 : (idle_mode == IDLE_BOTH) ? 30 : 0));
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [CFG_W-1:0] len;
    logic [OPC_W-1:0] op;
    logic [VB-1:0]    val;
    int unsigned      empty_pct;
    int unsigned      sel;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_opcode   = wmed_pkg::OP_PUSH;
    in_value_in = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, window length from reset
    send_item(wmed_pkg::OP_EMPTY, '1);             // empty push into an empty window
    send_item(wmed_pkg::OP_PUSH, '0);
    send_item(wmed_pkg::OP_PUSH, '1);              // even count: mean of min and max
    send_item(wmed_pkg::OP_PUSH, '1);
    send_item(wmed_pkg::OP_PUSH, '1);              // even count, middle sum overflows
    send_item(wmed_pkg::OP_EMPTY, 24'h123456);     // value ignored on empty push
    send_item(wmed_pkg::OP_PUSH, 24'h000100);
    send_item(wmed_pkg::OP_PUSH, 24'h800000);
    send_item(wmed_pkg::OP_PUSH, 24'h7FFFFF);

    // Directed, length below minimum clamps to two slots
    write_window('0);
    send_item(wmed_pkg::OP_PUSH, 24'h000005);
    send_item(wmed_pkg::OP_PUSH, 24'h000009);
    send_item(wmed_pkg::OP_PUSH, 24'h000004);      // evicts the oldest value
    send_item(wmed_pkg::OP_EMPTY, '0);
    send_item(wmed_pkg::OP_EMPTY, 24'hABCDEF);     // window back to no valid value
    send_item(wmed_pkg::OP_PUSH, 24'h000003);

    // Random phases, each with its own window length and idle pattern
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       len = 6'd1;
        1:       len = 6'd63;
        2:       len = 6'd2;
        3:       len = 6'd33;
        5:       len = 6'd32;
        default: len = CFG_W'($urandom_range(3, 31));
      endcase
      write_window(len);
      idle_mode <= idle_mode_t'(ph % 4);
      phase_no  <= ph;
      empty_pct = $urandom_range(5, 60);
      repeat (PHASE_ITEMS) begin
        op  = ($urandom_range(99) < empty_pct) ? wmed_pkg::OP_EMPTY : wmed_pkg::OP_PUSH;
        sel = $urandom_range(9);
        case (sel)
          0:       val = '0;
          1:       val = '1;
          2:       val = VB'($urandom_range(15));          // many duplicates
          3:       val = '1 - VB'($urandom_range(15));
          default: val = VB'($urandom);
        endcase
        send_item(op, val);
      end
    end

    // Drain and settle
    in_valid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (n_fail == 0 && n_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/wmed_pkg.sv
rtl/wmed_datapath.sv
rtl/wmed_ctrl.sv
rtl/windowed_median_with_empty_slots_top.sv
bench/wmed_checker.sv
bench/windowed_median_with_empty_slots_top_test.sv
